/* hw/rtl/wbps_pkg.sv */
// Shared constants, types and register codes of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int ADDRESS_BITS  = 48;
    localparam int REG_BYTES     = 16;
    localparam int REG_IDX_W     = $clog2(REG_BYTES);
    localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int OUT_ADDR_W    = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_BASE_ADDRESS = 3'd4
    } t_reg_idx;

    typedef logic [PATTERN_BYTES-1:0][7:0] t_window;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [15:0] care_mask;
        logic [4:0]  pattern_len;
        logic [47:0] base_address;
    } t_cfg;

    // Window as it stands once the incoming byte is shifted in.
    typedef struct packed {
        t_window                 window;
        logic [LEN_W-1:0]        fill;
        logic [ADDRESS_BITS-1:0] offset;
    } t_win_view;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] match_address;
        logic                  found;
        logic                  scan_done;
    } t_result;

endpackage

/* hw/rtl/wbps_window.sv */
// Byte window shift register, saturating fill count and running byte offset.
module wbps_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output wbps_pkg::t_win_view o_view
);
    import wbps_pkg::*;

    t_window                 r_window;
    t_window                 n_window;
    logic [LEN_W-1:0]        r_fill;
    logic [LEN_W-1:0]        n_fill;
    logic [ADDRESS_BITS-1:0] r_offset;

    always_comb begin
        for (int k = PATTERN_BYTES - 1; k > 0; k--) begin
            n_window[k] = r_window[k-1];
        end
        n_window[0] = i_data_byte;
        if (r_fill == LEN_W'(PATTERN_BYTES)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + LEN_W'(1);
        end
    end

    assign o_view.window = n_window;
    assign o_view.fill   = n_fill;
    assign o_view.offset = r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
            r_offset <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_window <= '0;
                r_fill   <= '0;
                r_offset <= '0;
            end else begin
                r_window <= n_window;
                r_fill   <= n_fill;
                r_offset <= r_offset + ADDRESS_BITS'(1);
            end
        end
    end

endmodule

/* hw/rtl/wbps_match.sv */
// Masked compare of the window against the pattern and match address computation.
module wbps_match (
    input  wbps_pkg::t_win_view i_view,
    input  wbps_pkg::t_cfg      i_cfg,
    input  logic                i_last_byte,
    output logic                o_hit,
    output wbps_pkg::t_result   o_result
);
    import wbps_pkg::*;

    logic [REG_BYTES-1:0][7:0] pat;
    logic [LEN_W-1:0]          len_eff;
    logic [PATTERN_BYTES-1:0]  pos_ok;
    logic [LEN_W-1:0]          j;
    logic [ADDRESS_BITS-1:0]   start_off;
    logic [ADDRESS_BITS-1:0]   sum;
    logic                      fill_ok;

    assign pat = {i_cfg.pattern_high, i_cfg.pattern_low};

    always_comb begin
        if (int'(i_cfg.pattern_len) > PATTERN_BYTES) begin
            len_eff = LEN_W'(PATTERN_BYTES);
        end else begin
            len_eff = LEN_W'(i_cfg.pattern_len);
        end

        // Window slot k lines up with pattern byte len-1-k; slots past the length are free.
        j = '0;
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            j = len_eff - LEN_W'(k) - LEN_W'(1);
            if (LEN_W'(k) >= len_eff) begin
                pos_ok[k] = 1'b1;
            end else if (int'(j) >= REG_BYTES) begin
                pos_ok[k] = 1'b1;
            end else if (!i_cfg.care_mask[j[REG_IDX_W-1:0]]) begin
                pos_ok[k] = 1'b1;
            end else begin
                pos_ok[k] = (i_view.window[k] == pat[j[REG_IDX_W-1:0]]);
            end
        end

        fill_ok = (i_view.fill >= len_eff);
        o_hit   = (len_eff == '0) || (fill_ok && (&pos_ok));

        if (len_eff == '0) begin
            start_off = i_view.offset;
        end else begin
            start_off = i_view.offset - ADDRESS_BITS'(len_eff)
                        + ADDRESS_BITS'(1);
        end
        sum = ADDRESS_BITS'(i_cfg.base_address) + start_off;

        o_result.match_address = o_hit ? OUT_ADDR_W'(sum) : '0;
        o_result.found         = o_hit;
        o_result.scan_done     = i_last_byte;
    end

endmodule

/* hw/rtl/wbps_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
module wbps_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wbps_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output wbps_pkg::t_result o_result
);
    import wbps_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_full   = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_result;
            end else begin
                r_out  <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

/* hw/rtl/wildcard_byte_pattern_scanner.sv */
// Top level: configuration registers, window, matcher and result buffer.
// Latency: a result appears on o_valid the cycle after the byte that causes it is accepted,
// provided the output register is free; otherwise it waits behind the stalled beat.
// Throughput: one byte per cycle; the window shift and the 16 masked compares finish in
// the accept cycle. During an output stall the skid register absorbs one more result
// beat, after which the input stalls until the output register drains.
// Reset (synchronous, active low): clears configuration, window, fill count, offset and
// the result buffer; the block is ready to take bytes as soon as reset is released.
module wildcard_byte_pattern_scanner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [wbps_pkg::OUT_ADDR_W-1:0] o_match_address,
    output logic                            o_found,
    output logic                            o_scan_done
);
    import wbps_pkg::*;

    t_cfg      r_cfg;
    t_win_view view;
    t_result   match_res;
    t_result   out_res;
    logic      hit;
    logic      accept;
    logic      push;
    logic      buf_full;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !buf_full;
    assign accept      = i_valid && o_ready;
    assign push        = accept && (hit || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PATTERN_LOW:  r_cfg.pattern_low  <= i_cfg_data;
                REG_PATTERN_HIGH: r_cfg.pattern_high <= i_cfg_data;
                REG_CARE_MASK:    r_cfg.care_mask    <= i_cfg_data[15:0];
                REG_PATTERN_LEN:  r_cfg.pattern_len  <= i_cfg_data[4:0];
                REG_BASE_ADDRESS: r_cfg.base_address <= i_cfg_data[47:0];
                default: begin
                end
            endcase
        end
    end

    wbps_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_view      (view)
    );

    wbps_match u_match (
        .i_view      (view),
        .i_cfg       (r_cfg),
        .i_last_byte (i_last_byte),
        .o_hit       (hit),
        .o_result    (match_res)
    );

    wbps_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (match_res),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_match_address = out_res.match_address;
    assign o_found         = out_res.found;
    assign o_scan_done     = out_res.scan_done;

    // Input side stalls only when both buffer entries hold a beat.
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    // The final byte always yields a result beat.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> o_valid)
        else $error("final byte produced no result");

    // The final byte restarts the offset of the next range.
    a_last_clears_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (view.offset == '0))
        else $error("offset not cleared after final byte");

    // A result without a match is only the end marker, with a zero address.
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_scan_done && (o_match_address == '0)))
        else $error("malformed end marker");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the wildcard byte pattern scanner, with its own scan predictor.
module testbench;
    import wbps_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_PHASE    = 3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES   = 70;
    localparam int STALL_PERIOD  = 7;
    localparam int STALL_OPEN    = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNMAPPED  = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    typedef enum int {SEND_STEADY, SEND_BURSTY} t_send_mode;
    typedef enum int {ACCEPT_ALWAYS, ACCEPT_LIGHT, ACCEPT_PERIODIC, ACCEPT_HEAVY} t_accept_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [7:0]              i_data_byte = '0;
    logic                    i_last_byte = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [OUT_ADDR_W-1:0]   o_match_address;
    logic                    o_found;
    logic                    o_scan_done;

    wildcard_byte_pattern_scanner u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_match_address (o_match_address),
        .o_found         (o_found),
        .o_scan_done     (o_scan_done)
    );

    // Predictor copy of the registers and of the scan state.
    logic [63:0]             cfg_pat_low = '0;
    logic [63:0]             cfg_pat_high = '0;
    logic [15:0]             cfg_care = '0;
    logic [4:0]              cfg_len = '0;
    logic [47:0]             cfg_base = '0;
    logic [7:0]              win_bytes [PATTERN_BYTES] = '{default: 8'h00};
    int                      win_fill = 0;
    logic [ADDRESS_BITS-1:0] next_offset = '0;

    t_stream_byte            byte_queue [$];
    t_result                 awaited_results [$];

    t_send_mode              send_mode = SEND_STEADY;
    t_accept_mode            accept_mode = ACCEPT_ALWAYS;
    int                      burst_left = 0;
    int                      gap_left = 0;
    int                      stall_phase = 0;
    int                      hold_left = 0;
    bit                      hold_armed = 1'b0;
    bit                      hold_done = 1'b0;

    int                      cycle_count = 0;
    int                      bytes_taken = 0;
    int                      results_seen = 0;
    int                      matches_seen = 0;
    int                      ranges_sent = 0;
    int                      settings_used = 0;
    int                      error_count = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [7:0] pattern_at(int j);
        if (j < 8) return cfg_pat_low[8*j +: 8];
        return cfg_pat_high[8*(j-8) +: 8];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int active_len();
        return (cfg_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(cfg_len);
    endfunction

    // Shift one byte into the window and queue the result it causes, if any.
    function automatic void predict_scan_step(logic [7:0] data, logic last);
        int                      len;
        logic [ADDRESS_BITS-1:0] start;
        logic                    hit;
        t_result                 res;
        len = active_len();
        start = next_offset;
        for (int k = PATTERN_BYTES - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = data;
        if (win_fill < PATTERN_BYTES) win_fill++;
        next_offset = next_offset + 1'b1;
        hit = 1'b0;
        if (len == 0) begin
            hit = 1'b1;
        end else if (win_fill >= len) begin
            hit = 1'b1;
            // Pattern byte j lines up with the byte taken len-1-j beats ago.
            for (int j = 0; j < len; j++) begin
                if (j < REG_BYTES && cfg_care[j] && win_bytes[len-1-j] != pattern_at(j)) begin
                    hit = 1'b0;
                end
            end
            start = start - ADDRESS_BITS'(len - 1);
        end
        start = start + cfg_base;
        if (last) begin
            foreach (win_bytes[k]) win_bytes[k] = '0;
            win_fill = 0;
            next_offset = '0;
        end
        if (hit || last) begin
            res.match_address = hit ? OUT_ADDR_W'(start) : '0;
            res.found = hit;
            res.scan_done = last;
            awaited_results.insert(awaited_results.size(), res);
        end
    endfunction

    // Byte driver: bursts of beats, separated by random gaps in the bursty send mode.
    always @(posedge i_clk) begin
        logic         nxt_valid;
        logic [7:0]   nxt_data;
        logic         nxt_last;
        t_stream_byte item;
        nxt_valid = i_valid;
        nxt_data = i_data_byte;
        nxt_last = i_last_byte;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_scan_step(i_data_byte, i_last_byte);
                bytes_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = (send_mode == SEND_BURSTY) ? $urandom_range(1, 9) : 0;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_queue.size() > 0) begin
                    item = byte_queue.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = item.data;
                    nxt_last = item.last;
                    burst_left--;
                end
            end
        end
        i_valid <= nxt_valid;
        i_data_byte <= nxt_data;
        i_last_byte <= nxt_last;
    end

    // Long receiver hold-off, started once when armed.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic willing;
        stall_phase = (stall_phase == STALL_PERIOD - 1) ? 0 : stall_phase + 1;
        case (accept_mode)
            ACCEPT_ALWAYS:   willing = 1'b1;
            ACCEPT_LIGHT:    willing = ($urandom_range(0, 3) != 0);
            ACCEPT_PERIODIC: willing = (stall_phase < STALL_OPEN);
            default:         willing = ($urandom_range(0, 1) != 0);
        endcase
        i_ready <= i_rst_n && willing && (hold_left == 0);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_found) matches_seen++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: match_address %h found %b scan_done %b",
                       o_match_address, o_found, o_scan_done);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_match_address !== want.match_address) begin
                    $error("match_address: expected %h, got %h",
                           want.match_address, o_match_address);
                    error_count++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, o_found);
                    error_count++;
                end
                if (o_scan_done !== want.scan_done) begin
                    $error("scan_done: expected %b, got %b", want.scan_done, o_scan_done);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  cfg_pat_low = value;
            REG_PATTERN_HIGH: cfg_pat_high = value;
            REG_CARE_MASK:    cfg_care = value[15:0];
            REG_PATTERN_LEN:  cfg_len = value[4:0];
            REG_BASE_ADDRESS: cfg_base = value[47:0];
            default: ;
        endcase
    endtask

    task automatic push_byte(logic [7:0] data, logic last);
        t_stream_byte item;
        item.data = data;
        item.last = last;
        byte_queue.insert(byte_queue.size(), item);
        if (last) ranges_sent++;
    endtask

    // Registers may only change once the block has gone quiet. The check runs at the
    // falling edge so that the driver's updates of the rising edge have settled.
    task automatic wait_drain();
        while (byte_queue.size() != 0 || i_valid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  range_bytes [$];
        int          phase_count;
        int          range_len;
        int          elen;
        int          pos;
        int          flip;
        int          shape;
        logic [47:0] base_pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern after reset: every byte matches at its own offset.
        // A write to an unmapped index must leave that behavior alone.
        write_reg(REG_FIRST_UNMAPPED, '1);
        settings_used++;
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_drain();

        // Short range ending before the window fills, then a match whose
        // address wraps past the top of the address space.
        write_reg(REG_PATTERN_LOW, 64'h0123_4567_00FF_80FF);
        write_reg(REG_CARE_MASK, 64'h0000_0000_0000_FFFD);
        write_reg(REG_PATTERN_LEN, 64'd4);
        write_reg(REG_BASE_ADDRESS, 64'h0000_FFFF_FFFF_FFFF);
        settings_used++;
        @(negedge i_clk);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h42, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h13, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drain();

        // Oversized length is clipped to the full window; both end bytes are wildcards.
        write_reg(REG_PATTERN_LOW, rand64());
        write_reg(REG_PATTERN_HIGH, rand64());
        write_reg(REG_CARE_MASK, 64'h0000_0000_0000_7FFE);
        write_reg(REG_PATTERN_LEN, 64'd31);
        write_reg(REG_BASE_ADDRESS, 64'h0000_0000_0000_1000);
        settings_used++;
        @(negedge i_clk);
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            push_byte(cfg_care[j] ? pattern_at(j) : 8'($urandom()), j == PATTERN_BYTES - 1);
        end
        wait_drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(REG_PATTERN_LOW, (p == 1) ? '1 : (p == 2) ? '0 : rand64());
            write_reg(REG_PATTERN_HIGH, (p == 1) ? '1 : (p == 2) ? '0 : rand64());
            case ($urandom_range(0, 3))
                0:       write_reg(REG_CARE_MASK, 64'h0000_0000_0000_FFFF);
                1:       write_reg(REG_CARE_MASK, '0);
                default: write_reg(REG_CARE_MASK, rand64());
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(REG_PATTERN_LEN, 64'd0);
                1:       write_reg(REG_PATTERN_LEN, 64'(PATTERN_BYTES));
                2:       write_reg(REG_PATTERN_LEN, 64'($urandom_range(PATTERN_BYTES + 1, 31)));
                default: write_reg(REG_PATTERN_LEN, 64'($urandom_range(1, 6)));
            endcase
            case ($urandom_range(0, 3))
                0:       base_pick = '0;
                1:       base_pick = '1;
                2:       base_pick = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 64));
                default: base_pick = 48'(rand64());
            endcase
            write_reg(REG_BASE_ADDRESS, 64'(base_pick));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(3'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_UNMAPPED)), rand64());
            end
            settings_used++;

            @(negedge i_clk);
            send_mode = (p == 0 || p == HOLD_PHASE) ? SEND_STEADY
                                                    : t_send_mode'($urandom_range(0, 1));
            accept_mode = (p == 0) ? ACCEPT_ALWAYS : t_accept_mode'($urandom_range(1, 3));
            if (p == HOLD_PHASE) hold_armed = 1'b1;
            elen = active_len();
            phase_count = 0;
            while (phase_count < PHASE_BYTES) begin
                range_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 30);
                range_bytes.delete();
                // Noise leans on pattern bytes so that partial matches are common.
                for (int k = 0; k < range_len; k++) begin
                    range_bytes.insert(range_bytes.size(), ($urandom_range(0, 2) == 0) ?
                                       pattern_at($urandom_range(0, REG_BYTES - 1)) :
                                       8'($urandom()));
                end
                shape = $urandom_range(0, 4);
                if (elen > 0 && range_len >= elen && shape != 0) begin
                    pos = $urandom_range(0, range_len - elen);
                    for (int j = 0; j < elen; j++) begin
                        if (cfg_care[j]) range_bytes[pos + j] = pattern_at(j);
                    end
                    if (shape == 1) begin
                        flip = $urandom_range(0, elen - 1);
                        range_bytes[pos + flip] = range_bytes[pos + flip] ^
                                                  8'($urandom_range(1, 255));
                    end
                end
                foreach (range_bytes[k]) push_byte(range_bytes[k], k == range_len - 1);
                phase_count += range_len;
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Scanned %0d bytes in %0d ranges under %0d register settings.",
                 bytes_taken, ranges_sent, settings_used);
        $display("Checked %0d results, %0d of them matches; %0d mismatches.",
                 results_seen, matches_seen, error_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
